/* design/oaht_pkg.sv */
package oaht_pkg;

    localparam int TABLE_SLOTS = 256;
    localparam int SLOT_BITS   = 8;
    localparam int HASH_BITS   = 32;
    localparam int VALUE_BITS  = 32;
    localparam int HITS_BITS   = 10;
    localparam int CNT_BITS    = 9;
    localparam int LOG2_BITS   = 4;
    localparam logic [LOG2_BITS-1:0] LOG2_RESET = 4'd8;

    typedef logic signed [HITS_BITS-1:0] t_hits;

    typedef enum logic [1:0] {
        ACT_FIND   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_MISS   = 2'd1,
        ST_EXISTS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // slot updates done after a probe
    typedef enum logic [2:0] {
        WR_NONE,
        WR_INS_NEW,
        WR_HEAD_INC,
        WR_HEAD_DEC,
        WR_MATCH_DEL,
        WR_HEAD_MOVE,
        WR_LAST_DEL,
        WR_HEAD_DEL
    } t_wr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_HEAD,
        S_WALK,
        S_DECIDE,
        S_WR_A,
        S_WR_B,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    accept;
        logic    head_scan;
        logic    walk_scan;
        logic    cnt_ins;
        logic    cnt_rem;
        t_wr     wr;
        logic    emit;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic    hd_stop;
        logic    hd_walk;
        logic    wk_stop;
        t_action action;
        logic    hit;
        logic    found;
        logic    have_pos;
        logic    match_is_head;
        logic    last_is_head;
    } t_dp_stat;

endpackage

/* design/oaht_ctrl.sv */
module oaht_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  oaht_pkg::t_dp_stat i_stat,
    output oaht_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);
    import oaht_pkg::*;

    t_state  r_state, n_state;
    t_wr     r_wr_a, r_wr_b, p_wr_a, p_wr_b;
    t_status r_status, p_status;
    logic    p_ins, p_rem;

    // work out the answer and the slot updates from the probe result
    always_comb begin
        p_status = ST_MISS;
        p_wr_a   = WR_NONE;
        p_wr_b   = WR_NONE;
        p_ins    = 1'b0;
        p_rem    = 1'b0;
        case (i_stat.action)
            ACT_FIND: begin
                if (i_stat.found) p_status = ST_OK;
            end
            ACT_INSERT: begin
                if (i_stat.found) begin
                    p_status = ST_EXISTS;
                end else if (i_stat.have_pos) begin
                    p_status = ST_OK;
                    p_wr_a   = WR_INS_NEW;
                    p_wr_b   = i_stat.hit ? WR_HEAD_INC : WR_NONE;
                    p_ins    = 1'b1;
                end else begin
                    p_status = ST_FULL;
                end
            end
            ACT_REMOVE: begin
                if (i_stat.found) begin
                    p_status = ST_OK;
                    p_rem    = 1'b1;
                    if (!i_stat.match_is_head) begin
                        p_wr_a = WR_HEAD_DEC;
                        p_wr_b = WR_MATCH_DEL;
                    end else if (!i_stat.last_is_head) begin
                        p_wr_a = WR_HEAD_MOVE;
                        p_wr_b = WR_LAST_DEL;
                    end else begin
                        p_wr_a = WR_HEAD_DEL;
                    end
                end
            end
            default: p_status = ST_MISS;
        endcase
    end

    // hold the plan once decided
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wr_a   <= WR_NONE;
            r_wr_b   <= WR_NONE;
            r_status <= ST_MISS;
        end else begin
            r_state <= n_state;
            if (r_state == S_DECIDE) begin
                r_wr_a   <= p_wr_a;
                r_wr_b   <= p_wr_b;
                r_status <= p_status;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (start) n_state = S_LOAD;
            S_LOAD:   n_state = (i_stat.action == ACT_NONE) ? S_DECIDE : S_HEAD;
            S_HEAD:   if (i_stat.hd_stop) n_state = i_stat.hd_walk ? S_WALK : S_DECIDE;
            S_WALK:   if (i_stat.wk_stop) n_state = S_DECIDE;
            S_DECIDE: n_state = S_WR_A;
            S_WR_A:   n_state = S_WR_B;
            S_WR_B:   n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd           = '0;
        o_cmd.wr        = WR_NONE;
        o_cmd.status    = r_status;
        o_busy          = (r_state != S_IDLE);
        case (r_state)
            S_IDLE:   o_cmd.accept = start;
            S_HEAD:   o_cmd.head_scan = 1'b1;
            S_WALK:   o_cmd.walk_scan = 1'b1;
            S_DECIDE: begin
                o_cmd.cnt_ins = p_ins;
                o_cmd.cnt_rem = p_rem;
            end
            S_WR_A:   o_cmd.wr = r_wr_a;
            S_WR_B:   o_cmd.wr = r_wr_b;
            S_DONE:   o_cmd.emit = 1'b1;
            default:  o_cmd.emit = 1'b0;
        endcase
    end

endmodule

/* design/oaht_dp.sv */
module oaht_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [oaht_pkg::LOG2_BITS-1:0]      i_cfg_wr_data,
    input  logic [1:0]                          i_action,
    input  logic [oaht_pkg::HASH_BITS-1:0]      i_hash,
    input  logic [oaht_pkg::VALUE_BITS-1:0]     i_key_value,
    input  oaht_pkg::t_dp_cmd                   i_cmd,
    output oaht_pkg::t_dp_stat                  o_stat,
    output logic                                o_result_valid,
    output logic [1:0]                          o_status,
    output logic [oaht_pkg::VALUE_BITS-1:0]     o_matched_value,
    output logic [oaht_pkg::SLOT_BITS-1:0]      o_slot_index
);
    import oaht_pkg::*;

    // slot storage
    logic [HASH_BITS-1:0]  hash_mem [TABLE_SLOTS];
    logic [VALUE_BITS-1:0] val_mem  [TABLE_SLOTS];
    t_hits                 hits_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_valid;

    logic [SLOT_BITS-1:0]  r_mask, n_mask;
    logic [CNT_BITS-1:0]   r_entries, r_deleted;

    // item registers
    t_action               r_action;
    logic [HASH_BITS-1:0]  r_hash;
    logic [VALUE_BITS-1:0] r_val;
    logic [SLOT_BITS-1:0]  r_home, r_ptr, r_n;

    // read port
    logic [SLOT_BITS-1:0]  r_rd_idx;
    t_hits                 r_rd_hits;
    logic [HASH_BITS-1:0]  r_rd_hash;
    logic [VALUE_BITS-1:0] r_rd_val;

    // probe registers
    logic                  r_have, n_have;
    logic [SLOT_BITS-1:0]  r_tomb, n_tomb;
    logic                  r_hit, n_hit;
    logic [SLOT_BITS-1:0]  r_head, n_head;
    t_hits                 r_head_hits, n_head_hits;
    logic                  r_found, n_found;
    logic [SLOT_BITS-1:0]  r_match, n_match;
    logic [VALUE_BITS-1:0] r_match_val, n_match_val;
    logic [SLOT_BITS-1:0]  r_last, n_last;
    logic [HASH_BITS-1:0]  r_last_hash, n_last_hash;
    logic [VALUE_BITS-1:0] r_last_val, n_last_val;
    logic [CNT_BITS-1:0]   r_members, n_members;
    logic                  r_have_pos, n_have_pos;
    logic [SLOT_BITS-1:0]  r_pos, n_pos;
    logic                  r_pos_tomb, n_pos_tomb;

    logic is_empty, is_del, home_eq, same, chain_done, is_ins, need_more;
    logic hd_stop, hd_walk, wk_stop;

    // write port
    logic                  wr_rec, wr_hits;
    logic [SLOT_BITS-1:0]  wr_addr;
    logic [HASH_BITS-1:0]  wr_hash;
    logic [VALUE_BITS-1:0] wr_val;
    t_hits                 wr_hits_d;

    // decode slots_log2 into the index mask
    always_comb begin
        if (i_cfg_wr_data >= LOG2_BITS'(SLOT_BITS))
            n_mask = '1;
        else if (i_cfg_wr_data < LOG2_BITS'(2))
            n_mask = SLOT_BITS'(3);
        else
            n_mask = SLOT_BITS'((9'd1 << i_cfg_wr_data) - 9'd1);
    end

    // classify the slot just read
    always_comb begin
        is_empty   = (r_rd_hits == '0);
        is_del     = r_rd_hits[HITS_BITS-1];
        home_eq    = ((r_rd_hash[SLOT_BITS-1:0] & r_mask) == r_home);
        same       = (r_rd_hash == r_hash) && (r_rd_val == r_val);
        chain_done = !(unsigned'(HITS_BITS'(r_members)) < unsigned'(r_head_hits));
        is_ins     = (r_action == ACT_INSERT);
    end

    // evaluate one probe step
    always_comb begin
        n_have      = r_have;
        n_tomb      = r_tomb;
        n_hit       = r_hit;
        n_head      = r_head;
        n_head_hits = r_head_hits;
        n_found     = r_found;
        n_match     = r_match;
        n_match_val = r_match_val;
        n_last      = r_last;
        n_last_hash = r_last_hash;
        n_last_val  = r_last_val;
        n_members   = r_members;
        n_have_pos  = r_have_pos;
        n_pos       = r_pos;
        n_pos_tomb  = r_pos_tomb;
        need_more   = 1'b0;
        hd_stop     = 1'b0;
        hd_walk     = 1'b0;
        wk_stop     = 1'b0;
        if (i_cmd.head_scan) begin
            if (is_empty) begin
                hd_stop    = 1'b1;
                n_have_pos = 1'b1;
                n_pos      = r_have ? r_tomb : r_rd_idx;
                n_pos_tomb = r_have;
            end else if (!is_del && home_eq) begin
                n_hit       = 1'b1;
                n_head      = r_rd_idx;
                n_head_hits = r_rd_hits;
                n_found     = same;
                n_match     = r_rd_idx;
                n_match_val = r_rd_val;
                n_last      = r_rd_idx;
                n_last_hash = r_rd_hash;
                n_last_val  = r_rd_val;
                n_members   = CNT_BITS'(1);
                n_have      = 1'b0;
                need_more   = (r_rd_hits > t_hits'(1)) || (is_ins && !same);
                hd_stop     = 1'b1;
                hd_walk     = need_more;
            end else begin
                if (is_del && !r_have) begin
                    n_have = 1'b1;
                    n_tomb = r_rd_idx;
                end
                if (r_n == r_mask) begin
                    hd_stop    = 1'b1;
                    n_have_pos = r_have || is_del;
                    n_pos      = r_have ? r_tomb : r_rd_idx;
                    n_pos_tomb = 1'b1;
                end
            end
        end else if (i_cmd.walk_scan) begin
            if (r_rd_idx == r_head) begin
                wk_stop    = 1'b1;
                n_have_pos = r_have;
                n_pos      = r_tomb;
                n_pos_tomb = 1'b1;
            end else if (is_del) begin
                if (!r_have) begin
                    n_have = 1'b1;
                    n_tomb = r_rd_idx;
                end
            end else if (is_empty) begin
                wk_stop    = 1'b1;
                n_have_pos = 1'b1;
                n_pos      = r_have ? r_tomb : r_rd_idx;
                n_pos_tomb = r_have;
            end else if (home_eq) begin
                if (chain_done) begin
                    // a member past the chain end leaves no slot
                    wk_stop    = 1'b1;
                    n_have_pos = 1'b0;
                end else begin
                    n_last      = r_rd_idx;
                    n_last_hash = r_rd_hash;
                    n_last_val  = r_rd_val;
                    n_members   = r_members + CNT_BITS'(1);
                    n_have      = 1'b0;
                    if (!r_found && same) begin
                        n_found     = 1'b1;
                        n_match     = r_rd_idx;
                        n_match_val = r_rd_val;
                    end
                    need_more = (unsigned'(HITS_BITS'(n_members)) < unsigned'(r_head_hits))
                              || (is_ins && !n_found);
                    wk_stop   = !need_more;
                end
            end
        end
    end

    // status to the controller
    always_comb begin
        o_stat.hd_stop       = hd_stop;
        o_stat.hd_walk       = hd_walk;
        o_stat.wk_stop       = wk_stop;
        o_stat.action        = r_action;
        o_stat.hit           = r_hit;
        o_stat.found         = r_found;
        o_stat.have_pos      = r_have_pos;
        o_stat.match_is_head = (r_match == r_head);
        o_stat.last_is_head  = (r_last == r_head);
    end

    // select the slot update
    always_comb begin
        wr_rec    = 1'b0;
        wr_hits   = 1'b1;
        wr_addr   = r_head;
        wr_hash   = r_hash;
        wr_val    = r_val;
        wr_hits_d = '1;
        case (i_cmd.wr)
            WR_INS_NEW: begin
                wr_rec    = 1'b1;
                wr_addr   = r_pos;
                wr_hits_d = t_hits'(1);
            end
            WR_HEAD_INC:  wr_hits_d = r_head_hits + t_hits'(1);
            WR_HEAD_DEC:  wr_hits_d = r_head_hits - t_hits'(1);
            WR_MATCH_DEL: wr_addr = r_match;
            WR_HEAD_MOVE: begin
                wr_rec    = 1'b1;
                wr_hash   = r_last_hash;
                wr_val    = r_last_val;
                wr_hits_d = r_head_hits - t_hits'(1);
            end
            WR_LAST_DEL:  wr_addr = r_last;
            WR_HEAD_DEL:  wr_addr = r_head;
            default:      wr_hits = 1'b0;
        endcase
    end

    // slot memories: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_rec) begin
            hash_mem[wr_addr] <= wr_hash;
            val_mem[wr_addr]  <= wr_val;
        end
        if (wr_hits)
            hits_mem[wr_addr] <= wr_hits_d;
        r_rd_idx  <= r_ptr;
        r_rd_hash <= hash_mem[r_ptr];
        r_rd_val  <= val_mem[r_ptr];
        r_rd_hits <= r_valid[r_ptr] ? hits_mem[r_ptr] : '0;
    end

    // valid bits, size and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_mask    <= '1;
            r_entries <= '0;
            r_deleted <= '0;
        end else if (i_cfg_wr_en) begin
            r_valid   <= '0;
            r_mask    <= n_mask;
            r_entries <= '0;
            r_deleted <= '0;
        end else begin
            if (wr_hits)
                r_valid[wr_addr] <= 1'b1;
            if (i_cmd.cnt_ins) begin
                r_entries <= r_entries + CNT_BITS'(1);
                if (r_pos_tomb && r_deleted != '0)
                    r_deleted <= r_deleted - CNT_BITS'(1);
            end
            if (i_cmd.cnt_rem) begin
                if (r_entries != '0)
                    r_entries <= r_entries - CNT_BITS'(1);
                r_deleted <= r_deleted + CNT_BITS'(1);
            end
        end
    end

    // latch the item, advance the probe
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action   <= t_action'(i_action);
            r_hash     <= i_hash;
            r_val      <= i_key_value;
            r_home     <= i_hash[SLOT_BITS-1:0] & r_mask;
            r_ptr      <= i_hash[SLOT_BITS-1:0] & r_mask;
            r_n        <= '0;
            r_have     <= 1'b0;
            r_tomb     <= '0;
            r_hit      <= 1'b0;
            r_head     <= '0;
            r_head_hits <= '0;
            r_found    <= 1'b0;
            r_match    <= '0;
            r_match_val <= '0;
            r_last     <= '0;
            r_last_hash <= '0;
            r_last_val <= '0;
            r_members  <= '0;
            r_have_pos <= 1'b0;
            r_pos      <= '0;
            r_pos_tomb <= 1'b0;
        end else begin
            r_ptr       <= (r_ptr + SLOT_BITS'(1)) & r_mask;
            if (i_cmd.head_scan)
                r_n <= r_n + SLOT_BITS'(1);
            r_have      <= n_have;
            r_tomb      <= n_tomb;
            r_hit       <= n_hit;
            r_head      <= n_head;
            r_head_hits <= n_head_hits;
            r_found     <= n_found;
            r_match     <= n_match;
            r_match_val <= n_match_val;
            r_last      <= n_last;
            r_last_hash <= n_last_hash;
            r_last_val  <= n_last_val;
            r_members   <= n_members;
            r_have_pos  <= n_have_pos;
            r_pos       <= n_pos;
            r_pos_tomb  <= n_pos_tomb;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            o_status <= i_cmd.status;
            case (i_cmd.status)
                ST_OK: begin
                    if (r_action == ACT_INSERT) begin
                        o_matched_value <= r_val;
                        o_slot_index    <= r_pos;
                    end else if (r_action == ACT_REMOVE) begin
                        o_matched_value <= r_val;
                        o_slot_index    <= r_match;
                    end else begin
                        o_matched_value <= r_match_val;
                        o_slot_index    <= r_match;
                    end
                end
                ST_EXISTS: begin
                    o_matched_value <= r_match_val;
                    o_slot_index    <= r_match;
                end
                default: begin
                    o_matched_value <= '0;
                    o_slot_index    <= '0;
                end
            endcase
        end
    end

endmodule

/* design/open_addressing_hash_table.sv */
// Linear-probing hash table with find, insert and remove by hash and value.
// Command channel: drive i_action, i_hash, i_key_value with start; the word is
// taken at a clock edge where start is high and busy is low. busy then stays
// high until the operation is finished.
// Result channel: o_result_valid pulses for one cycle with o_status,
// o_matched_value and o_slot_index. The receiver cannot stall; a result that
// is not taken in that cycle is gone.
// Sequence: from accept, a load state, then slots are probed one per cycle
// through the single read port of the slot memory: the chain search from the
// home slot, the chain walk and, for insert, the search for a free slot after
// the chain; then decide, write A, write B and done, before the result strobe.
// A new word may be started in the cycle the result is shown.
// Configuration: i_cfg_wr_en with i_cfg_wr_data sets log2 of the slot count
// and empties the table at once; write only while busy is low.
// Reset: the table is empty, both counts are zero and the size is 256 slots;
// no clearing pass is needed.
module open_addressing_hash_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [oaht_pkg::LOG2_BITS-1:0]  i_cfg_wr_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_action,
    input  logic [oaht_pkg::HASH_BITS-1:0]  i_hash,
    input  logic [oaht_pkg::VALUE_BITS-1:0] i_key_value,
    output logic                            o_result_valid,
    output logic [1:0]                      o_status,
    output logic [oaht_pkg::VALUE_BITS-1:0] o_matched_value,
    output logic [oaht_pkg::SLOT_BITS-1:0]  o_slot_index
);
    import oaht_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    oaht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    oaht_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_action        (i_action),
        .i_hash          (i_hash),
        .i_key_value     (i_key_value),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_matched_value (o_matched_value),
        .o_slot_index    (o_slot_index)
    );

endmodule

/* design/oaht_checker.sv */
module oaht_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            o_result_valid,
    input logic [1:0]                      o_status,
    input logic [oaht_pkg::VALUE_BITS-1:0] o_matched_value,
    input logic [oaht_pkg::SLOT_BITS-1:0]  o_slot_index
);
    import oaht_pkg::*;

    // a result only follows a busy operation
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without an operation in flight");

    // an accepted word makes the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // one result per word: never two strobes back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    // misses and full answers carry zero payload
    a_zero_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == ST_MISS || o_status == ST_FULL))
        |-> (o_matched_value == '0 && o_slot_index == '0))
        else $error("nonzero payload on a miss or full answer");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_valid  (o_result_valid),
    .o_status        (o_status),
    .o_matched_value (o_matched_value),
    .o_slot_index    (o_slot_index)
);

/* tb/sv/tb_open_addressing_hash_table.sv */
module tb_open_addressing_hash_table;
    import oaht_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        t_status     st;
        logic [31:0] val;
        logic [7:0]  slot;
    } t_result;

    typedef struct {
        t_action     act;
        logic [31:0] hash;
        logic [31:0] kval;
        logic [3:0]  cfg;      // nonzero: write this size before the word
        bit          typed;
        t_status     st;
        logic [31:0] val;
        logic [7:0]  slot;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [LOG2_BITS-1:0]  i_cfg_wr_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            i_action = ACT_FIND;
    logic [HASH_BITS-1:0]  i_hash = '0;
    logic [VALUE_BITS-1:0] i_key_value = '0;
    logic                  o_result_valid;
    logic [1:0]            o_status;
    logic [VALUE_BITS-1:0] o_matched_value;
    logic [SLOT_BITS-1:0]  o_slot_index;

    open_addressing_hash_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .start(start), .busy(busy),
        .i_action(i_action), .i_hash(i_hash), .i_key_value(i_key_value),
        .o_result_valid(o_result_valid), .o_status(o_status),
        .o_matched_value(o_matched_value), .o_slot_index(o_slot_index)
    );

    always #5 i_clk = ~i_clk;

    // table shadow
    logic [31:0] tbl_hash [TABLE_SLOTS];
    logic [31:0] tbl_value [TABLE_SLOTS];
    int          tbl_hits [TABLE_SLOTS];
    int unsigned used_cnt, del_cnt;
    logic [3:0]  size_log2;

    t_result     pending_results[$];
    int          errors = 0;
    int          cycles = 0;
    int          idle_pct = 0;
    logic [31:0] hash_pool [16];
    logic [31:0] val_pool [8];

    localparam int PR_HIT = 0;
    localparam int PR_SLOT = 1;
    localparam int PR_NONE = 2;

    function automatic void clear_shadow();
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            tbl_hits[i] = 0;
            tbl_hash[i] = '0;
            tbl_value[i] = '0;
        end
        used_cnt = 0;
        del_cnt = 0;
    endfunction

    function automatic int unsigned slot_count();
        int unsigned l;
        int unsigned s;
        l = size_log2;
        if (l < 2) l = 2;
        s = 1 << l;
        if (s > TABLE_SLOTS) s = TABLE_SLOTS;
        return s;
    endfunction

    // search from home for the chain head or a free slot
    function automatic int probe_home(input logic [31:0] h, input int unsigned sz,
                                      output int unsigned pos);
        int unsigned mask, home, i, tomb;
        bit have;
        mask = sz - 1; home = h & mask; i = home; tomb = 0; have = 0; pos = 0;
        for (int n = 0; n < sz; n++) begin
            if (tbl_hits[i] == 0) begin
                pos = have ? tomb : i;
                return PR_SLOT;
            end
            if (tbl_hits[i] < 0) begin
                if (!have) begin tomb = i; have = 1; end
            end else if ((tbl_hash[i] & mask) == home) begin
                pos = i;
                return PR_HIT;
            end
            i = (i + 1) & mask;
        end
        if (have) begin pos = tomb; return PR_SLOT; end
        return PR_NONE;
    endfunction

    // next member of the chain at head after slot from, or a free slot
    function automatic int probe_next(input int unsigned head, input int unsigned from,
                                      input int unsigned sz, output int unsigned pos);
        int unsigned mask, home, i, tomb;
        bit have;
        mask = sz - 1; home = tbl_hash[head] & mask; i = from; tomb = 0; have = 0;
        pos = 0;
        for (int n = 0; n < sz; n++) begin
            i = (i + 1) & mask;
            if (i == head) break;
            if (tbl_hits[i] < 0) begin
                if (!have) begin tomb = i; have = 1; end
                continue;
            end
            if (tbl_hits[i] == 0) begin
                pos = have ? tomb : i;
                return PR_SLOT;
            end
            if ((tbl_hash[i] & mask) == home) begin
                pos = i;
                return PR_HIT;
            end
        end
        if (have) begin pos = tomb; return PR_SLOT; end
        return PR_NONE;
    endfunction

    function automatic t_result table_op(input t_action act, input logic [31:0] h,
                                         input logic [31:0] v);
        t_result r;
        int unsigned sz, head, match, last, pos, cur, nxt;
        int pr, q;
        bit found;
        sz = slot_count();
        r.st = ST_MISS; r.val = '0; r.slot = '0;
        head = 0; match = 0; last = 0; pos = 0; found = 0;
        pr = (act != ACT_NONE) ? probe_home(h, sz, head) : PR_NONE;
        // walk the chain: first match and last member
        if (pr == PR_HIT) begin
            found = (tbl_hash[head] == h) && (tbl_value[head] == v);
            match = head;
            cur = head;
            for (int k = 1; k < tbl_hits[head]; k++) begin
                if (probe_next(head, cur, sz, nxt) != PR_HIT) break;
                cur = nxt;
                if (!found && tbl_hash[cur] == h && tbl_value[cur] == v) begin
                    found = 1;
                    match = cur;
                end
            end
            last = cur;
        end
        case (act)
            ACT_FIND: begin
                if (found) begin
                    r.st = ST_OK; r.slot = 8'(match); r.val = tbl_value[match];
                end
            end
            ACT_INSERT: begin
                if (found) begin
                    r.st = ST_EXISTS; r.slot = 8'(match); r.val = tbl_value[match];
                end else begin
                    if (pr == PR_HIT) q = probe_next(head, last, sz, pos);
                    else begin q = pr; pos = head; end
                    if (q != PR_SLOT) begin
                        r.st = ST_FULL;
                    end else begin
                        if (tbl_hits[pos] < 0 && del_cnt > 0) del_cnt--;
                        tbl_hash[pos] = h;
                        tbl_value[pos] = v;
                        tbl_hits[pos] = 1;
                        if (pr == PR_HIT) tbl_hits[head]++;
                        used_cnt++;
                        r.st = ST_OK; r.slot = 8'(pos); r.val = v;
                    end
                end
            end
            ACT_REMOVE: begin
                if (found) begin
                    if (match != head) begin
                        tbl_hits[head]--;
                        tbl_hits[match] = -1;
                    end else if (last != head) begin
                        tbl_hash[head] = tbl_hash[last];
                        tbl_value[head] = tbl_value[last];
                        tbl_hits[head]--;
                        tbl_hits[last] = -1;
                    end else begin
                        tbl_hits[head] = -1;
                    end
                    if (used_cnt > 0) used_cnt--;
                    del_cnt++;
                    r.st = ST_OK; r.slot = 8'(match); r.val = v;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d value=%h slot=%0d",
                         $time, o_status, o_matched_value, o_slot_index);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_status !== e.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, o_status);
                    errors++;
                end
                if (o_matched_value !== e.val) begin
                    $display("%0t: value expected %h actual %h", $time, e.val,
                             o_matched_value);
                    errors++;
                end
                if (o_slot_index !== e.slot) begin
                    $display("%0t: slot expected %0d actual %0d", $time, e.slot,
                             o_slot_index);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // drain outstanding results, then let the block settle
    task automatic wait_idle();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_size(input logic [3:0] l2);
        wait_idle();
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = l2;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        size_log2 = l2;
        clear_shadow();
    endtask

    // hand one word to the block; typed rows override the shadow's answer
    task automatic send_word(input t_action act, input logic [31:0] h,
                             input logic [31:0] v, input bit typed, input t_result tr);
        t_result r;
        if ($urandom_range(0, 99) < idle_pct) repeat ($urandom_range(1, 6)) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        i_action = act;
        i_hash = h;
        i_key_value = v;
        start = 1'b1;
        r = table_op(act, h, v);
        pending_results.push_back(typed ? tr : r);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    t_row rows[$];

    function automatic t_row mk(input t_action a, input logic [31:0] h,
                                input logic [31:0] v, input logic [3:0] cfg,
                                input bit typed, input t_status st,
                                input logic [31:0] rv, input logic [7:0] sl);
        t_row w;
        w.act = a; w.hash = h; w.kval = v; w.cfg = cfg; w.typed = typed;
        w.st = st; w.val = rv; w.slot = sl;
        return w;
    endfunction

    initial begin
        logic [3:0] sizes [8];
        t_result tr;
        t_action act;
        logic [31:0] h, v;
        int pick;

        sizes = '{4'd0, 4'd3, 4'd15, 4'd5, 4'd1, 4'd8, 4'd4, 4'd2};
        size_log2 = LOG2_RESET;
        clear_shadow();

        // 256 slots after reset: empty lookups, extremes, chain and head move
        rows.push_back(mk(ACT_FIND,   32'h0, 32'h0, 0, 1, ST_MISS, 0, 0));
        rows.push_back(mk(ACT_NONE,   '1, '1, 0, 1, ST_MISS, 0, 0));
        rows.push_back(mk(ACT_INSERT, 32'h0, 32'h0, 0, 1, ST_OK, 0, 0));
        rows.push_back(mk(ACT_INSERT, 32'h0, 32'h0, 0, 1, ST_EXISTS, 0, 0));
        rows.push_back(mk(ACT_INSERT, '1, '1, 0, 1, ST_OK, '1, 255));
        rows.push_back(mk(ACT_INSERT, 32'h100, 32'd5, 0, 1, ST_OK, 5, 1));
        rows.push_back(mk(ACT_INSERT, 32'h1ff, 32'd7, 0, 0, ST_OK, 0, 0));
        rows.push_back(mk(ACT_REMOVE, 32'h0, 32'h0, 0, 1, ST_OK, 0, 0));
        rows.push_back(mk(ACT_FIND,   32'h100, 32'd5, 0, 1, ST_OK, 5, 0));
        rows.push_back(mk(ACT_REMOVE, 32'h0, 32'h0, 0, 1, ST_MISS, 0, 0));
        rows.push_back(mk(ACT_REMOVE, 32'h100, 32'd5, 0, 0, ST_OK, 0, 0));
        rows.push_back(mk(ACT_FIND,   32'h1ff, 32'd7, 0, 0, ST_OK, 0, 0));
        // 4 slots: fill, overflow, tombstone reuse after a wrapped probe
        rows.push_back(mk(ACT_INSERT, 32'd1, 32'd10, 4'd2, 0, ST_OK, 0, 0));
        rows.push_back(mk(ACT_INSERT, 32'd5, 32'd11, 0, 0, ST_OK, 0, 0));
        rows.push_back(mk(ACT_INSERT, 32'd2, 32'd12, 0, 0, ST_OK, 0, 0));
        rows.push_back(mk(ACT_INSERT, 32'd3, 32'd13, 0, 0, ST_OK, 0, 0));
        rows.push_back(mk(ACT_INSERT, 32'd4, 32'd14, 0, 1, ST_FULL, 0, 0));
        rows.push_back(mk(ACT_REMOVE, 32'd5, 32'd11, 0, 0, ST_OK, 0, 0));
        rows.push_back(mk(ACT_INSERT, 32'd4, 32'd14, 0, 0, ST_OK, 0, 0));
        rows.push_back(mk(ACT_FIND,   32'd3, 32'd13, 0, 0, ST_OK, 0, 0));
        rows.push_back(mk(ACT_INSERT, 32'd6, 32'd15, 0, 1, ST_FULL, 0, 0));

        // hold reset
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (rows[i]) begin
            if (rows[i].cfg != 0) write_size(rows[i].cfg);
            tr.st = rows[i].st; tr.val = rows[i].val; tr.slot = rows[i].slot;
            send_word(rows[i].act, rows[i].hash, rows[i].kval, rows[i].typed, tr);
        end

        // random phases, one size each; sender idling changes per third
        foreach (sizes[p]) begin
            idle_pct = (p < 3) ? 19 : (p < 6) ? 83 : 0;
            write_size(sizes[p]);
            foreach (hash_pool[i]) hash_pool[i] = $urandom;
            foreach (val_pool[i]) val_pool[i] = $urandom;
            for (int n = 0; n < 225; n++) begin
                pick = $urandom_range(0, 99);
                act = (pick < 45) ? ACT_INSERT : (pick < 70) ? ACT_REMOVE :
                      (pick < 95) ? ACT_FIND : ACT_NONE;
                if ($urandom_range(0, 9) == 0) begin
                    h = $urandom;
                    v = $urandom;
                end else begin
                    h = hash_pool[$urandom_range(0, 15)];
                    v = val_pool[$urandom_range(0, 7)];
                end
                send_word(act, h, v, 0, tr);
            end
        end

        // drain and settle
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* open_addressing_hash_table.f */
design/oaht_pkg.sv
design/oaht_ctrl.sv
design/oaht_dp.sv
design/open_addressing_hash_table.sv
design/oaht_checker.sv
tb/sv/tb_open_addressing_hash_table.sv
